/* design/tpx_pkg.sv */
// Shared types and constants for the teletext PES line extractor.
// Used by tpx_front, tpx_line_buffer, tpx_back and the top level.
`default_nettype none

package tpx_pkg;

   // Line geometry
   localparam int LINE_BYTES = 42;
   localparam int POS_W      = 6;
   localparam int MEM_AW     = 7;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(LINE_BYTES - 1);

   // Input word of the request channel
   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
   } tpx_req_type;

   // Output word of the response channel
   typedef struct packed {
      logic [8:0]       line_number;
      logic [4:0]       slot_index;
      logic [POS_W-1:0] byte_position;
      logic [7:0]       payload_byte;
      logic             line_done;
   } tpx_rsp_type;

   // Per-line descriptor handed from front to back
   typedef struct packed {
      logic [8:0] line_number;
      logic [4:0] slot_index;
   } tpx_desc_type;

   // Front side write and push into the line buffer
   typedef struct packed {
      logic             wr_en;
      logic [POS_W-1:0] pos;
      logic [7:0]       data;
      logic             push;
      tpx_desc_type     desc;
   } tpx_wr_type;

   // Back side read request into the line buffer
   typedef struct packed {
      logic             rd_en;
      logic [POS_W-1:0] pos;
      logic             pop;
   } tpx_rd_type;

   // Reverse the bit order of one byte
   function automatic logic [7:0] bit_rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* design/tpx_front.sv */
// Front end: header skip, data identifier check and data unit parsing.
// Depends on tpx_pkg; writes payload bytes and descriptors into tpx_line_buffer.
`default_nettype none

module tpx_front
   import tpx_pkg::*;
#(
   parameter int MAX_LINES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire tpx_req_type req_data,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data,
   input  wire logic        bank_free,
   output tpx_wr_type       wr
);

   localparam int LT_W = $clog2(MAX_LINES + 1);

   // Parse phases
   localparam logic [2:0] PH_HEADER   = 3'd0;
   localparam logic [2:0] PH_IGNORE   = 3'd1;
   localparam logic [2:0] PH_UNIT_ID  = 3'd2;
   localparam logic [2:0] PH_UNIT_LEN = 3'd3;
   localparam logic [2:0] PH_BODY     = 3'd4;

   // Header and unit constants
   localparam logic [7:0] ID_LO_A    = 8'h10;
   localparam logic [7:0] ID_HI_A    = 8'h1F;
   localparam logic [7:0] ID_LO_B    = 8'h99;
   localparam logic [7:0] ID_HI_B    = 8'h9B;
   localparam logic [7:0] UNIT_EBU_A = 8'h02;
   localparam logic [7:0] UNIT_EBU_B = 8'h03;
   localparam logic [7:0] MIN_LEN    = 8'd44;
   localparam logic [7:0] FRAMING    = 8'hE4;
   localparam logic [7:0] SKIP_RESET = 8'd45;
   localparam logic [8:0] FIELD_BASE = 9'd313;
   localparam logic [7:0] PAYLOAD_END = 8'(LINE_BYTES + 2);

   logic [2:0]      phase_ff, phase_in;
   logic [7:0]      header_skip_ff, header_skip_in;
   logic [7:0]      header_count_ff, header_count_in;
   logic [7:0]      unit_count_ff, unit_count_in;
   logic [7:0]      unit_length_ff, unit_length_in;
   logic            usable_ff, usable_in;
   logic [5:0]      field_word_ff, field_word_in;
   logic [LT_W-1:0] lines_taken_ff, lines_taken_in;

   logic       accept;
   logic [7:0] b;
   logic       id_ok;
   logic [7:0] count_next;
   logic [8:0] line_number;

   assign req_ready = bank_free;
   assign accept    = req_valid && req_ready;
   assign b         = req_data.data_byte;
   assign id_ok     = (b >= ID_LO_A && b <= ID_HI_A) || (b >= ID_LO_B && b <= ID_HI_B);
   assign count_next = unit_count_ff + 8'd1;

   // Line number from the field/offset byte
   always_comb begin
      if (field_word_in[4:0] == 5'd0) begin
         line_number = 9'd0;
      end else if (field_word_in[5]) begin
         line_number = {4'd0, field_word_in[4:0]};
      end else begin
         line_number = {4'd0, field_word_in[4:0]} + FIELD_BASE;
      end
   end

   // Advance the parser on each accepted byte
   always_comb begin
      phase_in        = phase_ff;
      header_skip_in  = csr_wr_en ? csr_wr_data : header_skip_ff;
      header_count_in = header_count_ff;
      unit_count_in   = unit_count_ff;
      unit_length_in  = unit_length_ff;
      usable_in       = usable_ff;
      field_word_in   = field_word_ff;
      lines_taken_in  = lines_taken_ff;
      wr              = '0;

      if (accept) begin
         case (phase_ff)
            PH_HEADER: begin
               if (header_count_ff >= header_skip_ff) begin
                  phase_in = id_ok ? PH_UNIT_ID : PH_IGNORE;
               end else begin
                  header_count_in = header_count_ff + 8'd1;
               end
            end
            PH_UNIT_ID: begin
               usable_in = (b == UNIT_EBU_A) || (b == UNIT_EBU_B);
               phase_in  = PH_UNIT_LEN;
            end
            PH_UNIT_LEN: begin
               unit_length_in = b;
               usable_in      = usable_ff && (b >= MIN_LEN) &&
                                (lines_taken_ff < LT_W'(MAX_LINES));
               unit_count_in  = 8'd0;
               phase_in       = (b == 8'd0) ? PH_UNIT_ID : PH_BODY;
            end
            PH_BODY: begin
               if (unit_count_ff == 8'd0) begin
                  field_word_in = b[5:0];
               end else if (unit_count_ff == 8'd1) begin
                  if (b != FRAMING) begin
                     usable_in = 1'b0;
                  end
               end else if (unit_count_ff < PAYLOAD_END) begin
                  wr.wr_en = 1'b1;
                  wr.pos   = POS_W'(unit_count_ff - 8'd2);
                  wr.data  = bit_rev8(b);
               end
               unit_count_in = count_next;
               if (count_next >= unit_length_ff) begin
                  if (usable_in) begin
                     wr.push             = 1'b1;
                     wr.desc.line_number = line_number;
                     wr.desc.slot_index  = 5'(lines_taken_ff);
                     lines_taken_in      = lines_taken_ff + LT_W'(1);
                  end
                  usable_in = 1'b0;
                  phase_in  = PH_UNIT_ID;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase

         // Restart on the buffer's last byte
         if (req_data.buffer_end) begin
            phase_in        = PH_HEADER;
            header_count_in = 8'd0;
            unit_count_in   = 8'd0;
            unit_length_in  = 8'd0;
            usable_in       = 1'b0;
            lines_taken_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         header_skip_ff  <= SKIP_RESET;
         header_count_ff <= 8'd0;
         unit_count_ff   <= 8'd0;
         unit_length_ff  <= 8'd0;
         usable_ff       <= 1'b0;
         field_word_ff   <= 6'd0;
         lines_taken_ff  <= '0;
      end else begin
         phase_ff        <= phase_in;
         header_skip_ff  <= header_skip_in;
         header_count_ff <= header_count_in;
         unit_count_ff   <= unit_count_in;
         unit_length_ff  <= unit_length_in;
         usable_ff       <= usable_in;
         field_word_ff   <= field_word_in;
         lines_taken_ff  <= lines_taken_in;
      end
   end

endmodule

`default_nettype wire

/* design/tpx_line_buffer.sv */
// Ping-pong line store with a two-entry descriptor queue, one entry per bank.
// Depends on tpx_pkg; written by tpx_front, read by tpx_back.
`default_nettype none

module tpx_line_buffer
   import tpx_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire tpx_wr_type wr,
   input  wire tpx_rd_type rd,
   output logic            bank_free,
   output logic            head_valid,
   output tpx_desc_type    head_desc,
   output logic [7:0]      rd_data
);

   localparam int MEM_DEPTH = 2 * LINE_BYTES;

   logic [7:0]   line_mem_ff [MEM_DEPTH];
   logic [7:0]   rd_data_ff;
   tpx_desc_type desc_ff [2];
   logic [1:0]   busy_ff, busy_in;
   logic         wr_bank_ff, rd_bank_ff;
   logic [MEM_AW-1:0] wr_idx, rd_idx;

   assign wr_idx = wr_bank_ff ? MEM_AW'(wr.pos) + MEM_AW'(LINE_BYTES) : MEM_AW'(wr.pos);
   assign rd_idx = rd_bank_ff ? MEM_AW'(rd.pos) + MEM_AW'(LINE_BYTES) : MEM_AW'(rd.pos);

   assign bank_free  = !busy_ff[wr_bank_ff];
   assign head_valid = busy_ff[rd_bank_ff];
   assign head_desc  = desc_ff[rd_bank_ff];
   assign rd_data    = rd_data_ff;

   // Write payload bytes, read with registered data
   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         line_mem_ff[wr_idx] <= wr.data;
      end
      if (rd.rd_en) begin
         rd_data_ff <= line_mem_ff[rd_idx];
      end
   end

   // Hold the descriptor of each filled bank
   always_ff @(posedge clock) begin
      if (wr.push) begin
         desc_ff[wr_bank_ff] <= wr.desc;
      end
   end

   // Mark banks full on push, free on the last read
   always_comb begin
      busy_in = busy_ff;
      if (rd.pop) begin
         busy_in[rd_bank_ff] = 1'b0;
      end
      if (wr.push) begin
         busy_in[wr_bank_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 2'b00;
         wr_bank_ff <= 1'b0;
         rd_bank_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (wr.push) begin
            wr_bank_ff <= !wr_bank_ff;
         end
         if (rd.pop) begin
            rd_bank_ff <= !rd_bank_ff;
         end
      end
   end

   // A bank being drained must never be overwritten
   assert property (@(posedge clock) disable iff (reset)
      wr.wr_en |-> !busy_ff[wr_bank_ff])
      else $error("line store write into a bank that waits to be drained");

   assert property (@(posedge clock) disable iff (reset)
      wr.push |-> !busy_ff[wr_bank_ff])
      else $error("descriptor push into a full queue");

   assert property (@(posedge clock) disable iff (reset)
      (rd.rd_en || rd.pop) |-> busy_ff[rd_bank_ff])
      else $error("read from a bank that holds no line");

   assert property (@(posedge clock) disable iff (reset)
      (busy_ff == 2'b11) |-> (wr_bank_ff == rd_bank_ff))
      else $error("bank pointers out of step with the queue");

endmodule

`default_nettype wire

/* design/tpx_back.sv */
// Back end: drains one stored line as 42 response words.
// Depends on tpx_pkg; reads tpx_line_buffer, drives the response channel.
`default_nettype none

module tpx_back
   import tpx_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         head_valid,
   input  wire tpx_desc_type head_desc,
   input  wire logic [7:0]   rd_data,
   output tpx_rd_type        rd,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output tpx_rsp_type       rsp_data
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             s1_valid_ff, s1_valid_in;
   tpx_rsp_type      s1_meta_ff;
   tpx_rsp_type      s1_word;
   logic             out_valid_ff, out_valid_in;
   tpx_rsp_type      out_ff;

   logic adv, s1_open, issue, last;

   assign adv     = !out_valid_ff || rsp_ready;
   assign s1_open = !s1_valid_ff || adv;
   assign issue   = head_valid && s1_open;
   assign last    = (pos_ff == LAST_POS);

   // Issue one read per cycle while a line waits and stage one is open to take it
   always_comb begin
      rd.rd_en = issue;
      rd.pos   = pos_ff;
      rd.pop   = issue && last;
      pos_in   = pos_ff;
      if (issue) begin
         pos_in = last ? '0 : pos_ff + POS_W'(1);
      end
      s1_valid_in  = s1_open ? issue : s1_valid_ff;
      out_valid_in = adv ? s1_valid_ff : out_valid_ff;
   end

   // Join the read byte to its metadata
   always_comb begin
      s1_word              = s1_meta_ff;
      s1_word.payload_byte = rd_data;
   end

   // Capture word metadata alongside the memory read
   always_ff @(posedge clock) begin
      if (issue) begin
         s1_meta_ff.line_number   <= head_desc.line_number;
         s1_meta_ff.slot_index    <= head_desc.slot_index;
         s1_meta_ff.byte_position <= pos_ff;
         s1_meta_ff.payload_byte  <= 8'd0;
         s1_meta_ff.line_done     <= last;
      end
      if (adv) begin
         out_ff <= s1_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // Line end flag only on the last byte position
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.line_done == (rsp_data.byte_position == LAST_POS)))
      else $error("line_done out of step with byte_position");

   assert property (@(posedge clock) disable iff (reset)
      rd.pop |-> rd.rd_en)
      else $error("bank freed before its last byte was read");

   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !adv) |=> s1_valid_ff)
      else $error("stage one word lost under stall");

endmodule

`default_nettype wire

/* design/teletext_pes_line_extractor.sv */
// Top level of the teletext PES line extractor.
// Depends on tpx_pkg, tpx_front, tpx_line_buffer and tpx_back.
//
//   Channel  Direction  Handshake             Word
//   req_     in         req_valid/req_ready   tpx_req_type: data_byte, buffer_end
//   rsp_     out        rsp_valid/rsp_ready   tpx_rsp_type: line, slot, position, byte, done
//   csr_     in         csr_wr_en             csr_wr_data = header_skip
//
// One PES byte is taken per cycle. A taken line is stored into one of two line banks
// and drained as 42 words, one per cycle while rsp_ready is high.
// The input stalls only while the bank it would write still waits to be drained,
// i.e. when both banks hold lines not yet read out. Reset is synchronous and
// clears the parser, the bank queue and the output register; header_skip resets to 45.
`default_nettype none

module teletext_pes_line_extractor
   import tpx_pkg::*;
#(
   parameter int MAX_LINES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire tpx_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output tpx_rsp_type      rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);

   tpx_wr_type   wr;
   tpx_rd_type   rd;
   logic         bank_free;
   logic         head_valid;
   tpx_desc_type head_desc;
   logic [7:0]   rd_data;

   tpx_front #(
      .MAX_LINES (MAX_LINES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .bank_free   (bank_free),
      .wr          (wr)
   );

   tpx_line_buffer u_line_buffer (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .rd         (rd),
      .bank_free  (bank_free),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .rd_data    (rd_data)
   );

   tpx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .rd_data    (rd_data),
      .rd         (rd),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
